>>> design/pcu_pkg.sv
`default_nettype none

package pcu_pkg;

  localparam int unsigned IdW     = 32;
  localparam int unsigned OpW     = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [IdW-1:0] KeepId  = '1;
  localparam logic [IdW-1:0] CapFull = '1;

  typedef logic [IdW-1:0] id_t;

  typedef enum logic [OpW-1:0] {
    OP_RESEED    = 5'd0,
    OP_GET_UID   = 5'd1,
    OP_GET_EUID  = 5'd2,
    OP_GET_GID   = 5'd3,
    OP_GET_EGID  = 5'd4,
    OP_GETRESUID = 5'd5,
    OP_GETRESGID = 5'd6,
    OP_SETUID    = 5'd7,
    OP_SETGID    = 5'd8,
    OP_SETREUID  = 5'd9,
    OP_SETREGID  = 5'd10,
    OP_SETRESUID = 5'd11,
    OP_SETRESGID = 5'd12,
    OP_SETFSUID  = 5'd13,
    OP_SETFSGID  = 5'd14,
    OP_CAPSET    = 5'd15,
    OP_CAPGET    = 5'd16
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_PERM  = 2'd1,
    ST_UNSUP = 2'd2
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED_UID = 1'd0,
    CFG_SEED_GID = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    id_t real_id;
    id_t eff_id;
    id_t saved_id;
    id_t fs_id;
  } fam_t;

  typedef struct packed {
    fam_t usr;
    fam_t grp;
  } cred_t;

  typedef struct packed {
    logic [OpW-1:0] opcode;
    id_t            id_a;
    id_t            id_b;
    id_t            id_c;
  } req_t;

  typedef struct packed {
    status_t status;
    id_t     value;
    id_t     value_second;
    id_t     value_third;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/pcu_req_if.sv
`default_nettype none

interface pcu_req_if;
  logic                        valid;
  logic                        ready;
  logic [pcu_pkg::OpW-1:0]     opcode;
  logic [pcu_pkg::IdW-1:0]     id_a;
  logic [pcu_pkg::IdW-1:0]     id_b;
  logic [pcu_pkg::IdW-1:0]     id_c;

  modport source (output valid, opcode, id_a, id_b, id_c, input ready);
  modport sink (input valid, opcode, id_a, id_b, id_c, output ready);
endinterface

`default_nettype wire

>>> design/pcu_rsp_if.sv
`default_nettype none

interface pcu_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [pcu_pkg::StatusW-1:0] status;
  logic [pcu_pkg::IdW-1:0]     value;
  logic [pcu_pkg::IdW-1:0]     value_second;
  logic [pcu_pkg::IdW-1:0]     value_third;

  modport source (output valid, status, value, value_second, value_third, input ready);
  modport sink (input valid, status, value, value_second, value_third, output ready);
endinterface

`default_nettype wire

>>> design/pcu_cfg_if.sv
`default_nettype none

interface pcu_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pcu_pkg::CfgIdxW-1:0] index;
  logic [pcu_pkg::IdW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/pcu_exec.sv
`default_nettype none

module pcu_exec (
  input  pcu_pkg::cred_t cur,
  input  pcu_pkg::id_t   seed_uid,
  input  pcu_pkg::id_t   seed_gid,
  input  pcu_pkg::req_t  req,
  output pcu_pkg::cred_t nxt,
  output pcu_pkg::rsp_t  res
);
  import pcu_pkg::*;

  logic priv;
  fam_t fam;
  fam_t fam_new;
  logic fam_wr;
  id_t  a, b, c;
  logic a_keep, b_keep, c_keep;
  logic a_in, b_in, c_in;

  assign priv   = (cur.usr.eff_id == '0);
  assign fam    = req.opcode[0] ? cur.usr : cur.grp;
  assign a      = req.id_a;
  assign b      = req.id_b;
  assign c      = req.id_c;
  assign a_keep = (a == KeepId);
  assign b_keep = (b == KeepId);
  assign c_keep = (c == KeepId);
  assign a_in   = (a == fam.real_id) || (a == fam.eff_id) || (a == fam.saved_id);
  assign b_in   = (b == fam.real_id) || (b == fam.eff_id) || (b == fam.saved_id);
  assign c_in   = (c == fam.real_id) || (c == fam.eff_id) || (c == fam.saved_id);

  always_comb begin
    nxt     = cur;
    fam_new = fam;
    fam_wr  = 1'b0;
    res     = '{status: ST_OK, value: '0, value_second: '0, value_third: '0};

    unique case (op_t'(req.opcode)) inside
      OP_RESEED: begin
        nxt.usr = '{real_id: seed_uid, eff_id: seed_uid, saved_id: seed_uid, fs_id: seed_uid};
        nxt.grp = '{real_id: seed_gid, eff_id: seed_gid, saved_id: seed_gid, fs_id: seed_gid};
      end
      OP_GET_UID:  res.value = cur.usr.real_id;
      OP_GET_EUID: res.value = cur.usr.eff_id;
      OP_GET_GID:  res.value = cur.grp.real_id;
      OP_GET_EGID: res.value = cur.grp.eff_id;
      OP_GETRESUID, OP_GETRESGID: begin
        res.value        = fam.real_id;
        res.value_second = fam.eff_id;
        res.value_third  = fam.saved_id;
      end
      OP_SETUID, OP_SETGID: begin
        if (!a_keep) begin
          if (priv) begin
            fam_new = '{real_id: a, eff_id: a, saved_id: a, fs_id: a};
            fam_wr  = 1'b1;
          end else if (a == fam.real_id || a == fam.saved_id) begin
            fam_new.eff_id = a;
            fam_new.fs_id  = a;
            fam_wr         = 1'b1;
          end else begin
            res.status = ST_PERM;
          end
        end
      end
      OP_SETREUID, OP_SETREGID: begin
        // real may only take the old real or effective id when unprivileged
        if (!priv && ((!a_keep && a != fam.real_id && a != fam.eff_id) || (!b_keep && !b_in)))
        begin
          res.status = ST_PERM;
        end else begin
          fam_new.real_id = a_keep ? fam.real_id : a;
          fam_new.eff_id  = b_keep ? fam.eff_id : b;
          if (!a_keep || (!b_keep && b != fam.real_id)) begin
            fam_new.saved_id = fam_new.eff_id;
          end
          fam_new.fs_id = fam_new.eff_id;
          fam_wr        = 1'b1;
        end
      end
      OP_SETRESUID, OP_SETRESGID: begin
        if (!priv && ((!a_keep && !a_in) || (!b_keep && !b_in) || (!c_keep && !c_in))) begin
          res.status = ST_PERM;
        end else begin
          fam_new.real_id  = a_keep ? fam.real_id : a;
          fam_new.eff_id   = b_keep ? fam.eff_id : b;
          fam_new.saved_id = c_keep ? fam.saved_id : c;
          fam_new.fs_id    = fam_new.eff_id;
          fam_wr           = 1'b1;
        end
      end
      OP_SETFSUID, OP_SETFSGID: begin
        res.value = fam.fs_id;
        if (!a_keep && (priv || a_in || a == fam.fs_id)) begin
          fam_new.fs_id = a;
          fam_wr        = 1'b1;
        end
      end
      OP_CAPSET: res.status = priv ? ST_OK : ST_PERM;
      OP_CAPGET: res.value = priv ? CapFull : '0;
      default:   res.status = ST_UNSUP;
    endcase

    if (fam_wr) begin
      if (req.opcode[0]) begin
        nxt.usr = fam_new;
      end else begin
        nxt.grp = fam_new;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/posix_credential_unit.sv
`default_nettype none

// Credential unit: holds real/effective/saved/fs user and group ids and
// serves one request per clock while the result side keeps taking. A request
// is captured in an input register, evaluated against the current ids in the
// following cycle, and its result lands in an output register. The id update
// and the result of a request are committed in the same cycle, so the next
// request always sees the ids left by the one before it. Seed registers are
// written through the cfg channel, which is always ready; reseed copies them
// into all eight ids.
module posix_credential_unit (
  input  wire      clk,
  input  wire      rst,
  pcu_req_if.sink   req,
  pcu_rsp_if.source rsp,
  pcu_cfg_if.sink   cfg
);
  import pcu_pkg::*;

  id_t   seed_uid;
  id_t   seed_gid;
  cred_t cred;
  cred_t cred_next;
  req_t  s1_req;
  logic  s1_valid;
  rsp_t  out_rsp;
  rsp_t  res_next;
  logic  out_valid;
  logic  adv;

  assign adv       = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_uid <= '0;
      seed_gid <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_SEED_UID: seed_uid <= cfg.data;
        CFG_SEED_GID: seed_gid <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= '{opcode: req.opcode, id_a: req.id_a, id_b: req.id_b, id_c: req.id_c};
    end
  end

  pcu_exec u_exec (
    .cur      (cred),
    .seed_uid (seed_uid),
    .seed_gid (seed_gid),
    .req      (s1_req),
    .nxt      (cred_next),
    .res      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cred <= '0;
    end else if (adv) begin
      cred <= cred_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rsp <= res_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_rsp.status;
  assign rsp.value        = out_rsp.value;
  assign rsp.value_second = out_rsp.value_second;
  assign rsp.value_third  = out_rsp.value_third;

  // ids only move when a request is evaluated
  a_cred_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(cred))
    else $error("credentials changed with no request evaluated");

  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("evaluated request produced no result");

  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while both stages are full");

  a_capget_priv: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_req.opcode == OP_CAPGET && cred.usr.eff_id == '0) |=> rsp.value == CapFull)
    else $error("privileged capability query lost the full mask");

endmodule

`default_nettype wire

>>> tb/sv/posix_credential_unit_tb.sv
`timescale 1ns / 1ps

module posix_credential_unit_tb;
  import pcu_pkg::*;

  localparam logic [OpW-1:0] OpFirstUnknown = OpW'(OP_CAPGET + 1);
  localparam logic [OpW-1:0] OpLastUnknown  = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcu_req_if req_ch ();
  pcu_rsp_if rsp_ch ();
  pcu_cfg_if cfg_ch ();

  posix_credential_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #1 clk = ~clk;

  // predicted credential state and seed registers
  fam_t cur_usr = '0;
  fam_t cur_grp = '0;
  id_t  seed_uid_reg = '0;
  id_t  seed_gid_reg = '0;

  rsp_t due_replies[$];
  int   fail_count = 0;
  bit   src_idle = 1'b0;
  bit   sink_idle = 1'b0;
  int   hold_request = 0;

  function automatic logic in_family(fam_t f, id_t v);
    return v == f.real_id || v == f.eff_id || v == f.saved_id;
  endfunction

  function automatic status_t set_sole(inout fam_t f, input logic priv, input id_t v);
    status_t st;
    st = ST_OK;
    if (v != KeepId) begin
      if (priv) begin
        f = {4{v}};
      end else if (v == f.real_id || v == f.saved_id) begin
        f.eff_id = v;
        f.fs_id  = v;
      end else begin
        st = ST_PERM;
      end
    end
    return st;
  endfunction

  function automatic status_t set_re(inout fam_t f, input logic priv, input id_t r,
                                     input id_t e);
    status_t st;
    id_t     ne;
    st = ST_OK;
    if (r != KeepId && !priv && r != f.real_id && r != f.eff_id) st = ST_PERM;
    if (e != KeepId && !priv && !in_family(f, e)) st = ST_PERM;
    if (st == ST_OK) begin
      ne = (e != KeepId) ? e : f.eff_id;
      // saved follows new effective; compare against the old real id
      if (r != KeepId || (e != KeepId && e != f.real_id)) f.saved_id = ne;
      if (r != KeepId) f.real_id = r;
      f.eff_id = ne;
      f.fs_id  = ne;
    end
    return st;
  endfunction

  function automatic status_t set_res(inout fam_t f, input logic priv, input id_t r,
                                      input id_t e, input id_t s);
    status_t st;
    st = ST_OK;
    if (!priv) begin
      if (r != KeepId && !in_family(f, r)) st = ST_PERM;
      if (e != KeepId && !in_family(f, e)) st = ST_PERM;
      if (s != KeepId && !in_family(f, s)) st = ST_PERM;
    end
    if (st == ST_OK) begin
      if (r != KeepId) f.real_id = r;
      if (e != KeepId) f.eff_id = e;
      if (s != KeepId) f.saved_id = s;
      f.fs_id = f.eff_id;
    end
    return st;
  endfunction

  function automatic id_t set_fs(inout fam_t f, input logic priv, input id_t v);
    id_t old;
    old = f.fs_id;
    if (v != KeepId && (priv || in_family(f, v) || v == f.fs_id)) f.fs_id = v;
    return old;
  endfunction

  function automatic rsp_t predict_reply(req_t r);
    rsp_t res;
    fam_t f;
    logic priv;
    logic touched;
    res     = '0;
    touched = 1'b0;
    priv    = (cur_usr.eff_id == '0);
    f       = r.opcode[0] ? cur_usr : cur_grp;
    case (r.opcode) inside
      OP_RESEED: begin
        cur_usr = {4{seed_uid_reg}};
        cur_grp = {4{seed_gid_reg}};
      end
      OP_GET_UID:  res.value = cur_usr.real_id;
      OP_GET_EUID: res.value = cur_usr.eff_id;
      OP_GET_GID:  res.value = cur_grp.real_id;
      OP_GET_EGID: res.value = cur_grp.eff_id;
      OP_GETRESUID, OP_GETRESGID: begin
        res.value        = f.real_id;
        res.value_second = f.eff_id;
        res.value_third  = f.saved_id;
      end
      OP_SETUID, OP_SETGID: begin
        res.status = set_sole(f, priv, r.id_a);
        touched    = 1'b1;
      end
      OP_SETREUID, OP_SETREGID: begin
        res.status = set_re(f, priv, r.id_a, r.id_b);
        touched    = 1'b1;
      end
      OP_SETRESUID, OP_SETRESGID: begin
        res.status = set_res(f, priv, r.id_a, r.id_b, r.id_c);
        touched    = 1'b1;
      end
      OP_SETFSUID, OP_SETFSGID: begin
        res.value = set_fs(f, priv, r.id_a);
        touched   = 1'b1;
      end
      OP_CAPSET: res.status = priv ? ST_OK : ST_PERM;
      OP_CAPGET: res.value = priv ? CapFull : '0;
      default:   res.status = ST_UNSUP;
    endcase
    if (touched) begin
      if (r.opcode[0]) cur_usr = f;
      else cur_grp = f;
    end
    return res;
  endfunction

  // often ids the family already holds, so unprivileged changes often pass
  function automatic id_t pick_id(fam_t f);
    case ($urandom_range(0, 9)) inside
      0:       return KeepId;
      1:       return f.real_id;
      2:       return f.eff_id;
      3:       return f.saved_id;
      4:       return f.fs_id;
      5, 6:    return id_t'($urandom_range(0, 3));
      default: return id_t'($urandom());
    endcase
  endfunction

  task automatic send_request(logic [OpW-1:0] op, id_t a, id_t b, id_t c);
    req_t r;
    int   gap;
    r.opcode = op;
    r.id_a   = a;
    r.id_b   = b;
    r.id_c   = c;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.id_a   <= a;
    req_ch.id_b   <= b;
    req_ch.id_c   <= c;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    due_replies.push_back(predict_reply(r));
  endtask

  task automatic send_random_request();
    logic [OpW-1:0] op;
    fam_t           f;
    int             pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) op = OP_RESEED;
    else if (pick < 9) op = OpW'($urandom_range(OpFirstUnknown, OpLastUnknown));
    else op = OpW'($urandom_range(OP_GET_UID, OP_CAPGET));
    f = op[0] ? cur_usr : cur_grp;
    send_request(op, pick_id(f), pick_id(f), pick_id(f));
  endtask

  task automatic wait_all_replies();
    req_ch.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_seeds(id_t uid, id_t gid);
    wait_all_replies();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_SEED_UID;
    cfg_ch.data  <= uid;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    seed_uid_reg = uid;
    cfg_ch.index <= CFG_SEED_GID;
    cfg_ch.data  <= gid;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    seed_gid_reg = gid;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_request(OP_GETRESUID, KeepId, KeepId, KeepId);
    send_request(OP_GETRESGID, '0, '0, '0);
    send_request(OP_GET_UID, '0, '0, '0);
    send_request(OP_GET_EGID, '0, '0, '0);
    send_request(OP_CAPGET, '0, '0, '0);
  endtask

  // ends unprivileged: uid real 10, eff 20; gid 7/8/9 with fs near the top
  task automatic test_privileged_changes();
    write_seeds(32'd0, 32'd100);
    send_request(OP_CAPSET, '0, '0, '0);
    send_request(OP_RESEED, KeepId, KeepId, KeepId);
    send_request(OP_SETGID, KeepId, 32'd5, 32'd5);
    send_request(OP_SETRESGID, 32'd7, 32'd8, 32'd9);
    send_request(OP_SETFSGID, 32'hFFFF_FFFE, '0, '0);
    send_request(OP_SETREUID, 32'd10, 32'd20, KeepId);
  endtask

  task automatic test_unprivileged_rules();
    send_request(OP_CAPSET, '0, '0, '0);
    send_request(OP_CAPGET, '0, '0, '0);
    send_request(OP_SETUID, 32'd5, '0, '0);
    send_request(OP_SETUID, 32'd10, '0, '0);
    send_request(OP_SETREUID, KeepId, 32'd20, '0);
    send_request(OP_SETREUID, 32'd30, KeepId, '0);
    send_request(OP_SETRESUID, KeepId, KeepId, 32'd20);
    send_request(OP_SETRESUID, 32'd1, KeepId, KeepId);
    send_request(OP_SETFSUID, 32'd99, '0, '0);
    send_request(OP_SETGID, 32'd8, '0, '0);
    send_request(OP_SETREGID, 32'd8, 32'd9, '0);
    send_request(OP_GET_EUID, '0, '0, '0);
    send_request(OP_GET_GID, '0, '0, '0);
  endtask

  task automatic test_unknown_opcodes();
    send_request(OpFirstUnknown, KeepId, KeepId, KeepId);
    send_request(OpLastUnknown, '0, '0, '0);
    send_request(OP_RESEED, '0, '0, '0);
  endtask

  task automatic test_seed_phases();
    id_t uid_seed[6];
    id_t gid_seed[6];
    uid_seed = '{32'd0, KeepId, 32'd1, 32'd0, id_t'($urandom()), 32'd2};
    gid_seed = '{32'd0, KeepId, 32'd0, id_t'($urandom()), id_t'($urandom()), 32'hFFFF_FFFE};
    for (int p = 0; p < 6; p++) begin
      write_seeds(uid_seed[p], gid_seed[p]);
      src_idle  = p[0];
      sink_idle = p[1];
      send_request(OP_RESEED, '0, '0, '0);
      repeat (150) send_random_request();
    end
  endtask

  task automatic test_result_backpressure();
    wait_all_replies();
    src_idle     = 1'b0;
    sink_idle    = 1'b0;
    hold_request = 60;
    repeat (40) send_random_request();
  endtask

  task automatic test_sender_pause();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (3) begin
      repeat (15) send_random_request();
      wait_all_replies();
    end
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin
    int gap;
    int hold;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        hold         = hold_request;
        hold_request = 0;
        rsp_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = sink_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_replies.size() == 0) begin
        $error("reply with no request outstanding");
        fail_count++;
      end else begin
        want = due_replies.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, rsp_ch.value);
          fail_count++;
        end
        if (rsp_ch.value_second !== want.value_second) begin
          $error("value_second: expected %h, got %h", want.value_second,
                 rsp_ch.value_second);
          fail_count++;
        end
        if (rsp_ch.value_third !== want.value_third) begin
          $error("value_third: expected %h, got %h", want.value_third,
                 rsp_ch.value_third);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_RESEED;
    req_ch.id_a   <= '0;
    req_ch.id_b   <= '0;
    req_ch.id_c   <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= CFG_SEED_UID;
    cfg_ch.data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_privileged_changes();
    test_unprivileged_rules();
    test_unknown_opcodes();
    test_seed_phases();
    test_result_backpressure();
    test_sender_pause();
    wait_all_replies();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
